### rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/nst_pkg.sv
// Types and constants for the note sequence tick table.
// No dependencies; imported by every module of the block.
package nst_pkg;

	localparam int FUNC_W     = 2;
	localparam int PITCH_W    = 8;
	localparam int DUR_IO_W   = 16;
	localparam int TICK_W     = 22;
	localparam int COUNT_IO_W = 7;
	localparam int STATUS_W   = 2;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 56;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH  = 2'd0,
		FN_POP   = 2'd1,
		FN_CLEAR = 2'd2,
		FN_CHECK = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_POP  = 5'b00100,
		S_SCAN = 5'b01000,
		S_DONE = 5'b10000
	} seq_state_t;

	typedef struct packed {
		status_t                 status;
		logic [TICK_W-1:0]       total;
		logic [COUNT_IO_W-1:0]   count;
		logic [DUR_IO_W-1:0]     duration;
		logic [PITCH_W-1:0]      pitch;
		logic                    hit;
	} result_t;

	typedef struct packed {
		logic done;
		logic take;
	} res_hs_t;

endpackage

### rtl/nst_table.sv
// Note table memory: one write port, one registered read port.
// Depends on nst_pkg for field widths.
module nst_table import nst_pkg::*; #(
	parameter int DEPTH         = 64,
	parameter int DURATION_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]                    wr_addr,
	input  logic [PITCH_W+DURATION_BITS+TICK_W-1:0]     wr_data,
	input  logic                                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]                    rd_addr,
	output logic [PITCH_W+DURATION_BITS+TICK_W-1:0]     rd_data
);

	localparam int EW = PITCH_W + DURATION_BITS + TICK_W;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/nst_alu.sv
// Shared tick unit: add or subtract for the running total, equality for the scan.
// Depends on nst_pkg for the tick width and operation type.
module nst_alu import nst_pkg::*; (
	input  alu_op_t            op,
	input  logic [TICK_W-1:0]  a,
	input  logic [TICK_W-1:0]  b,
	output logic [TICK_W-1:0]  res,
	output logic               eq
);

	always_comb begin
		case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			default: res = a;
		endcase
	end

	assign eq = (a == b);

endmodule

### rtl/nst_ctrl.sv
// Sequencer: runs each operation over the table and the shared tick unit.
// Depends on nst_pkg, nst_alu; drives the port of nst_table.
module nst_ctrl import nst_pkg::*; #(
	parameter int DEPTH         = 64,
	parameter int DURATION_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  func_t                                    in_func,
	input  logic [PITCH_W-1:0]                       in_pitch,
	input  logic [DUR_IO_W-1:0]                      in_duration,
	input  logic [TICK_W-1:0]                        in_tick,
	output logic                                     wr_en,
	output logic [$clog2(DEPTH)-1:0]                 wr_addr,
	output logic [PITCH_W+DURATION_BITS+TICK_W-1:0]  wr_data,
	output logic                                     rd_en,
	output logic [$clog2(DEPTH)-1:0]                 rd_addr,
	input  logic [PITCH_W+DURATION_BITS+TICK_W-1:0]  rd_data,
	input  res_hs_t                                  hs_in,
	output logic                                     res_done,
	output result_t                                  res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DB = DURATION_BITS;

	seq_state_t           state_q;
	func_t                func_q;
	logic [PITCH_W-1:0]   pitch_q;
	logic [DB-1:0]        dur_q;
	logic [TICK_W-1:0]    tick_q;
	logic [CW-1:0]        count_q;
	logic [TICK_W-1:0]    total_q;
	logic [AW-1:0]        idx_q;
	logic                 hit_q;
	logic [PITCH_W-1:0]   res_pitch_q;
	logic [DB-1:0]        res_dur_q;
	status_t              status_q;

	logic [PITCH_W-1:0]   rd_pitch;
	logic [DB-1:0]        rd_dur;
	logic [TICK_W-1:0]    rd_start;
	logic                 full;
	logic                 empty;
	logic                 last_idx;
	logic                 in_fire;
	alu_op_t              alu_op;
	logic [TICK_W-1:0]    alu_a;
	logic [TICK_W-1:0]    alu_b;
	logic [TICK_W-1:0]    alu_res;
	logic                 alu_eq;

	assign {rd_pitch, rd_dur, rd_start} = rd_data;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		alu_op = (state_q == S_POP) ? ALU_SUB : ALU_ADD;
		alu_a  = (state_q == S_SCAN) ? rd_start : total_q;
		case (state_q)
			S_EXEC:  alu_b = TICK_W'(dur_q);
			S_POP:   alu_b = TICK_W'(rd_dur);
			S_SCAN:  alu_b = tick_q;
			default: alu_b = '0;
		endcase
	end

	nst_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.eq  (alu_eq)
	);

	assign wr_en   = (state_q == S_EXEC) && (func_q == FN_PUSH) && !full;
	assign wr_addr = AW'(count_q);
	assign wr_data = {pitch_q, dur_q, total_q};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == S_SCAN) begin
			rd_en   = 1'b1;
			rd_addr = idx_q + AW'(1);
		end else if (state_q == S_EXEC) begin
			if (func_q == FN_POP) begin
				rd_en   = 1'b1;
				rd_addr = AW'(count_q - CW'(1));
			end else if (func_q == FN_CHECK) begin
				rd_en   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (func_q)
						FN_PUSH: begin
							if (!full) begin
								total_q <= alu_res;
								count_q <= count_q + CW'(1);
							end
							state_q <= S_DONE;
						end
						FN_POP: begin
							state_q <= empty ? S_DONE : S_POP;
						end
						FN_CLEAR: begin
							count_q <= '0;
							total_q <= '0;
							state_q <= S_DONE;
						end
						FN_CHECK: begin
							state_q <= empty ? S_DONE : S_SCAN;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_POP: begin
					total_q <= alu_res;
					count_q <= count_q - CW'(1);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (alu_eq || last_idx) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (hs_in.done && hs_in.take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q      <= in_func;
			pitch_q     <= in_pitch;
			dur_q       <= DB'(in_duration);
			tick_q      <= in_tick;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			res_pitch_q <= '0;
			res_dur_q   <= '0;
			status_q    <= ST_OK;
		end
		if (state_q == S_EXEC) begin
			if (func_q == FN_PUSH && full) begin
				status_q <= ST_FULL;
			end
			if (func_q == FN_POP && empty) begin
				status_q <= ST_EMPTY;
			end
		end
		if (state_q == S_SCAN) begin
			idx_q <= idx_q + AW'(1);
			if (alu_eq) begin
				hit_q       <= 1'b1;
				res_pitch_q <= rd_pitch;
				res_dur_q   <= rd_dur;
			end
		end
	end

	assign res_done     = (state_q == S_DONE);
	assign res.hit      = hit_q;
	assign res.pitch    = res_pitch_q;
	assign res.duration = DUR_IO_W'(res_dur_q);
	assign res.count    = COUNT_IO_W'(count_q);
	assign res.total    = total_q;
	assign res.status   = status_q;

endmodule

### rtl/note_sequence_tick_table.sv
// Note sequence tick table: ordered note store with running start ticks.
// Depends on nst_pkg, nst_table, nst_ctrl (which holds nst_alu).
//
// Usage:
//   Input transfers on s_tvalid/s_tready carry one operation in s_tuser
//   (push, pop newest, clear, check tick) and its operands in s_tdata.
//   Every input transfer yields exactly one result transfer on
//   m_tvalid/m_tready: hit flag, matched pitch and duration, entry count,
//   running total and status.
//   Push and clear run through the execute state to the done state; pop
//   adds a pop state between them, and check scans the entries in order
//   until a match or the end of the table (an empty table skips the
//   scan). The check scan reads one entry per cycle from the single table
//   read port and runs its start tick through the shared tick unit.
//   s_tready is high only while no operation is in progress; the next
//   operation is taken the cycle after the result moves into the output
//   register, even while that result still waits for m_tready.
//   A stalled receiver holds m_tdata; once the output register and the
//   sequencer both hold a result, s_tready stays low.
//   Reset empties the table and zeroes the total; no clearing pass.
module note_sequence_tick_table import nst_pkg::*; #(
	parameter int DEPTH         = 64,
	parameter int DURATION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// pitch_in[7:0], duration_in[23:8], query_tick[45:24], zero pad[47:46]
	input  logic [S_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [FUNC_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit[0], pitch_out[8:1], duration_out[24:9], entry_count[31:25],
	// total_ticks[53:32], status[55:54], zero pad none
	output logic [M_DATA_W-1:0]  m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = PITCH_W + DURATION_BITS + TICK_W;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [EW-1:0]        rd_data;
	res_hs_t              hs;
	logic                 res_done;
	result_t              res;
	logic                 m_tvalid_q;
	result_t              out_q;

	nst_table #(
		.DEPTH         (DEPTH),
		.DURATION_BITS (DURATION_BITS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nst_ctrl #(
		.DEPTH         (DEPTH),
		.DURATION_BITS (DURATION_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_func     (func_t'(s_tuser)),
		.in_pitch    (s_tdata[7:0]),
		.in_duration (s_tdata[23:8]),
		.in_tick     (s_tdata[45:24]),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.hs_in       (hs),
		.res_done    (res_done),
		.res         (res)
	);

	assign hs.done = res_done;
	assign hs.take = res_done && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (hs.take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hs.take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

### rtl/nst_chk.sv
// Port checker for the note sequence tick table, bound to the top level.
// Depends on assert_macros.svh and nst_pkg for the status codes.
`include "assert_macros.svh"

module nst_chk import nst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	`NST_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`NST_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`NST_ASSERT_NXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`NST_ASSERT_IMP(a_hit_ok, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[55:54] == ST_OK)

endmodule

bind note_sequence_tick_table nst_chk u_chk (.*);
